@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// boolean condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

@@ rtl/ckl_pkg.sv @@
// shared types, widths and codes of the compacting keyed list
package ckl_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int OP_W    = 2;
  localparam int KEY_W   = 16;
  localparam int PAY_W   = 16;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 4;
  localparam int ENTRY_W = 5;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

  // controller to datapath commands, at most one active per cycle
  typedef struct packed {
    logic load;
    logic match;
    logic pick;
    logic apply;
  } ckl_cmd_t;

endpackage

@@ rtl/ckl_ctrl.sv @@
// sequencing controller: accept, compare, select, update and result hand-off
`include "assert_macros.svh"

module ckl_ctrl
  import ckl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ckl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_PICK,
    S_APPLY
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  // output register is free when empty or being drained this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o       = '0;
    cmd_o.load  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.match = (state_q == S_MATCH);
    cmd_o.pick  = (state_q == S_PICK);
    cmd_o.apply = (state_q == S_APPLY) && out_free;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_MATCH;
          end
        end
        S_MATCH: state_q <= S_PICK;
        S_PICK:  state_q <= S_APPLY;
        S_APPLY: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (cmd_o.apply) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `ASSERT_PROP(a_accept_to_match, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> (state_q == S_MATCH), "accepted beat did not start compare")
  `ASSERT_PROP(a_cmd_onehot0, clk_i, rst_ni, $onehot0(cmd_o), "more than one datapath command")
  `ASSERT_PROP(a_apply_gives_result, clk_i, rst_ni, cmd_o.apply |=> (out_valid_q && state_q == S_IDLE), "update without result beat")
  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd_o.apply && out_valid_q && out_stall_i, "result overwritten while stalled")

endmodule

@@ rtl/ckl_dp.sv @@
// datapath: entry cells, parallel key compare, first-match select, shift and result register
`include "assert_macros.svh"

module ckl_dp
  import ckl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ckl_cmd_t           cmd_i,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [PAY_W-1:0]   payload_i,
  output logic [STAT_W-1:0]  status_o,
  output logic [PAY_W-1:0]   found_payload_o,
  output logic [POS_W-1:0]   found_position_o,
  output logic [ENTRY_W-1:0] entry_count_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAPACITY);

  // latched input beat
  logic [OP_W-1:0]  op_q;
  logic [KEY_W-1:0] srch_key_q;
  logic [PAY_W-1:0] new_pay_q;

  // entry cells
  logic [KEY_W-1:0] key_mem_q [CAPACITY];
  logic [PAY_W-1:0] pay_mem_q [CAPACITY];
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;

  // compare and select stages
  logic [CAPACITY-1:0] match_d, match_q;
  logic [CAPACITY-1:0] first_q;
  logic [CAPACITY-1:0] below_q;

  // result register
  logic [STAT_W-1:0]  status_q, status_d;
  logic [PAY_W-1:0]   fpay_q, fpay_d;
  logic [POS_W-1:0]   fpos_q, fpos_d;
  logic [ENTRY_W-1:0] fcount_q;

  logic             hit;
  logic [IDX_W-1:0] pos_sel;
  logic [PAY_W-1:0] pay_sel;
  logic             add_en;
  logic             rem_en;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_d[i] = (key_mem_q[i] == srch_key_q) && (CNT_W'(i) < count_q);
    end
  end

  // one-hot of the first match drives encode and payload select
  always_comb begin
    pos_sel = '0;
    pay_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_q[i]) begin
        pos_sel = pos_sel | IDX_W'(i);
        pay_sel = pay_sel | pay_mem_q[i];
      end
    end
  end

  assign hit = |first_q;

  always_comb begin
    status_d = ST_DONE;
    fpay_d   = '0;
    fpos_d   = '0;
    count_d  = count_q;
    add_en   = 1'b0;
    rem_en   = 1'b0;
    case (op_q)
      OP_ADD: begin
        if (count_q < CNT_MAX) begin
          add_en  = 1'b1;
          count_d = count_q + CNT_W'(1);
        end else begin
          status_d = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          rem_en  = 1'b1;
          count_d = count_q - CNT_W'(1);
          fpos_d  = POS_W'(pos_sel);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      OP_FIND: begin
        if (hit) begin
          fpay_d = pay_sel;
          fpos_d = POS_W'(pos_sel);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.apply) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= operation_i;
      srch_key_q <= key_i;
      new_pay_q  <= payload_i;
    end
    if (cmd_i.match) begin
      match_q <= match_d;
    end
    if (cmd_i.pick) begin
      first_q <= match_q & (~match_q + CAPACITY'(1));
      below_q <= ~match_q & (match_q - CAPACITY'(1));
    end
    if (cmd_i.apply) begin
      status_q <= status_d;
      fpay_q   <= fpay_d;
      fpos_q   <= fpos_d;
      fcount_q <= ENTRY_W'(count_d);
    end
  end

  // cells at and above the removed one take their upper neighbor
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd_i.apply && add_en && (CNT_W'(i) == count_q)) begin
        key_mem_q[i] <= srch_key_q;
        pay_mem_q[i] <= new_pay_q;
      end else if (cmd_i.apply && rem_en && !below_q[i] && (i + 1 < CAPACITY)) begin
        key_mem_q[i] <= key_mem_q[(i + 1) % CAPACITY];
        pay_mem_q[i] <= pay_mem_q[(i + 1) % CAPACITY];
      end
    end
  end

  assign status_o         = status_q;
  assign found_payload_o  = fpay_q;
  assign found_position_o = fpos_q;
  assign entry_count_o    = fcount_q;

  `ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CNT_MAX, "entry count above capacity")
  `ASSERT_PROP(a_first_onehot0, clk_i, rst_ni, cmd_i.apply |-> $onehot0(first_q), "first match not one-hot")
  `ASSERT_PROP(a_add_counts_up, clk_i, rst_ni, (cmd_i.apply && add_en) |=> (count_q == $past(count_q) + CNT_W'(1)), "add did not grow the list")
  `ASSERT_PROP(a_remove_counts_down, clk_i, rst_ni, (cmd_i.apply && rem_en) |=> (count_q == $past(count_q) - CNT_W'(1)), "remove did not shrink the list")

endmodule

@@ rtl/compacting_keyed_list.sv @@
// top level of the compacting keyed list
//
// Holds up to CAPACITY entries of a 16-bit key and a 16-bit payload handle,
// in insertion order. The input channel (in_valid_i / in_stall_o) carries an
// operation code, a key and a payload: add appends at the tail, remove drops
// the first entry with a matching key and closes the gap, find looks up the
// first matching entry. Each input beat gives exactly one output beat
// (out_valid_o / out_stall_i) with status, found payload, found position and
// the entry count after the operation.
// Each item steps through accept, compare the key against every cell at
// once, pick the first match, then update the cells and load the result
// register. The input stalls until the item has left its update step, so
// a new input beat is taken only once the previous item is done.
// The result register sits between the two sides; while the receiver stalls,
// the held result stays put and the next item still runs up to its update
// step, where it waits until the register frees.
// Reset clears the entry count and the handshake state; the cells themselves
// are not cleared, as only entries below the count are ever looked at.

module compacting_keyed_list
  import ckl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [PAY_W-1:0]   payload_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [STAT_W-1:0]  status_o,
  output logic [PAY_W-1:0]   found_payload_o,
  output logic [POS_W-1:0]   found_position_o,
  output logic [ENTRY_W-1:0] entry_count_o
);

  ckl_cmd_t cmd;

  ckl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  ckl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .operation_i      (operation_i),
    .key_i            (key_i),
    .payload_i        (payload_i),
    .status_o         (status_o),
    .found_payload_o  (found_payload_o),
    .found_position_o (found_position_o),
    .entry_count_o    (entry_count_o)
  );

endmodule

@@ sim/compacting_keyed_list_tb.sv @@
// self-checking testbench of the compacting keyed list
`timescale 1ns / 100ps

module compacting_keyed_list_tb;
  import ckl_pkg::*;

  localparam int LIST_DEPTH  = CAPACITY_DEF;
  localparam int HOLD_CYCLES = 250;
  localparam int RAND_ITEMS  = 850;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 8;

  // the one operation code the block ignores
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [PAY_W-1:0]   pay;
    logic [POS_W-1:0]   pos;
    logic [ENTRY_W-1:0] count;
  } list_result_t;

  class list_scoreboard;
    logic [KEY_W-1:0] key_mem [LIST_DEPTH];
    logic [PAY_W-1:0] pay_mem [LIST_DEPTH];
    int unsigned      fill;
    list_result_t     pending_q [$];
    int unsigned      error_cnt;
    int unsigned      result_cnt;
    int unsigned      full_cnt;
    int unsigned      miss_cnt;
    int unsigned      top_fill;
    int unsigned      op_cnt [4];

    // update the list copy for an accepted input beat and queue its result
    function void note_beat(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                            logic [PAY_W-1:0] pay);
      list_result_t want;
      int pos;
      want = '0;
      pos = -1;
      op_cnt[op]++;
      if (op == OP_REMOVE || op == OP_FIND) begin
        for (int i = int'(fill) - 1; i >= 0; i--) begin
          if (key_mem[i] == key) pos = i;
        end
      end
      case (op)
        OP_ADD: begin
          if (fill < LIST_DEPTH) begin
            key_mem[fill] = key;
            pay_mem[fill] = pay;
            fill++;
          end else begin
            want.status = ST_FULL;
            full_cnt++;
          end
        end
        OP_REMOVE: begin
          if (pos < 0) begin
            want.status = ST_NOT_FOUND;
            miss_cnt++;
          end else begin
            for (int j = pos; j < int'(fill) - 1; j++) begin
              key_mem[j] = key_mem[j+1];
              pay_mem[j] = pay_mem[j+1];
            end
            fill--;
            want.pos = POS_W'(pos);
          end
        end
        OP_FIND: begin
          if (pos < 0) begin
            want.status = ST_NOT_FOUND;
            miss_cnt++;
          end else begin
            want.pay = pay_mem[pos];
            want.pos = POS_W'(pos);
          end
        end
        default: ;
      endcase
      if (fill > top_fill) top_fill = fill;
      want.count = ENTRY_W'(fill);
      pending_q.push_back(want);
    endfunction

    function void check_beat(list_result_t got);
      list_result_t want;
      result_cnt++;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing outstanding");
        error_cnt++;
        return;
      end
      want = pending_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        error_cnt++;
      end
      if (got.pay !== want.pay) begin
        $error("found_payload: expected %0h, got %0h", want.pay, got.pay);
        error_cnt++;
      end
      if (got.pos !== want.pos) begin
        $error("found_position: expected %0d, got %0d", want.pos, got.pos);
        error_cnt++;
      end
      if (got.count !== want.count) begin
        $error("entry_count: expected %0d, got %0d", want.count, got.count);
        error_cnt++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [OP_W-1:0]    operation_i;
  logic [KEY_W-1:0]   key_i;
  logic [PAY_W-1:0]   payload_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [STAT_W-1:0]  status_o;
  logic [PAY_W-1:0]   found_payload_o;
  logic [POS_W-1:0]   found_position_o;
  logic [ENTRY_W-1:0] entry_count_o;

  list_scoreboard sb = new();
  bit          stim_done;
  bit          held_long;
  int unsigned burst_left;
  int unsigned cycle_cnt;

  compacting_keyed_list #(
    .CAPACITY(LIST_DEPTH)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .key_i           (key_i),
    .payload_i       (payload_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .found_payload_o (found_payload_o),
    .found_position_o(found_position_o),
    .entry_count_o   (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_beat('{status_o, found_payload_o, found_position_o, entry_count_o});
    end
  end

  // offer one beat, hold it until taken, then maybe pause between bursts
  task automatic push_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [PAY_W-1:0] pay);
    int unsigned gap;
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_i       <= key;
    payload_i   <= pay;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_beat(op, key, pay);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // mostly keys already in the list, some from a narrow range, some anywhere
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (sb.fill != 0 && r < 6) return sb.key_mem[$urandom_range(0, sb.fill - 1)];
    if (r < 8) return KEY_W'($urandom_range(0, 7));
    return KEY_W'($urandom);
  endfunction

  // mode 0 grows the list, mode 1 shrinks it, mode 2 is balanced
  function automatic logic [OP_W-1:0] pick_op(int unsigned mode);
    int unsigned r;
    int unsigned add_pct;
    int unsigned rem_pct;
    r = $urandom_range(0, 99);
    add_pct = (mode == 0) ? 60 : (mode == 1) ? 20 : 35;
    rem_pct = (mode == 0) ? 20 : (mode == 1) ? 55 : 30;
    if (r < 3) return OP_NOP;
    if (r < 3 + add_pct) return OP_ADD;
    if (r < 3 + add_pct + rem_pct) return OP_REMOVE;
    return OP_FIND;
  endfunction

  // receiver: stall patterns in stretches, plus one long hold-off
  initial begin
    int unsigned stretch;
    int unsigned mode;
    out_stall_i <= 1'b0;
    wait (rst_ni);
    while (!stim_done) begin
      if (!held_long && sb.result_cnt > 100) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        held_long = 1'b1;
      end else begin
        stretch = $urandom_range(10, 60);
        mode = $urandom_range(0, 3);
        repeat (stretch) begin
          case (mode)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= ($urandom_range(0, 1) == 0);
            2: out_stall_i <= ($urandom_range(0, 3) != 0);
            default: out_stall_i <= ($urandom_range(0, 7) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
    out_stall_i <= 1'b0;
  end

  initial begin
    int unsigned counted;
    int unsigned mode;
    int unsigned mode_left;
    logic [OP_W-1:0] op;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    operation_i <= OP_ADD;
    key_i       <= '0;
    payload_i   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: misses and an ignored code
    push_item(OP_FIND, 16'h0000, 16'hFFFF);
    push_item(OP_REMOVE, 16'hFFFF, 16'h0000);
    push_item(OP_NOP, 16'hFFFF, 16'hFFFF);
    // extreme keys and payloads, with a duplicate key
    push_item(OP_ADD, 16'h0000, 16'h0000);
    push_item(OP_ADD, 16'hFFFF, 16'hFFFF);
    push_item(OP_ADD, 16'h0000, 16'hA5A5);
    push_item(OP_FIND, 16'h0000, 16'h1234);
    push_item(OP_FIND, 16'hFFFF, 16'h0000);
    push_item(OP_REMOVE, 16'h0000, 16'h0000);
    push_item(OP_FIND, 16'h0000, 16'h0000);
    // fill to capacity, overflow, then hit the last slot
    for (int i = 0; i < LIST_DEPTH - 2; i++) begin
      push_item(OP_ADD, KEY_W'(16'h0100 + i), PAY_W'(16'h5A00 + i));
    end
    push_item(OP_ADD, 16'h7777, 16'h8888);
    push_item(OP_FIND, KEY_W'(16'h0100 + LIST_DEPTH - 3), 16'h0000);
    push_item(OP_REMOVE, KEY_W'(16'h0100 + LIST_DEPTH - 3), 16'h0000);

    counted = 0;
    mode_left = 0;
    mode = 2;
    while (counted < RAND_ITEMS) begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(30, 100);
      end
      mode_left--;
      op = pick_op(mode);
      push_item(op, pick_key(), PAY_W'($urandom));
      if (op != OP_NOP) counted++;
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("ran %0d add, %0d remove, %0d find and %0d ignored beats; %0d results checked",
             sb.op_cnt[OP_ADD], sb.op_cnt[OP_REMOVE], sb.op_cnt[OP_FIND],
             sb.op_cnt[OP_NOP], sb.result_cnt);
    $display("list peaked at %0d of %0d entries; %0d adds found it full, %0d lookups missed",
             sb.top_fill, LIST_DEPTH, sb.full_cnt, sb.miss_cnt);
    if (sb.error_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
